### rtl/core/gwwl_pkg.sv
// Shared types, codes and the glyph width table for the greedy word-wrap line breaker.
// Depends on nothing; every other file refers to it by scoped names.
package gwwl_pkg;

  localparam int WIDTH_W  = 20;
  localparam int OFFSET_W = 16;
  localparam int INDEX_W  = 7;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX  = 20'hFFFFF;
  localparam logic [WIDTH_W-1:0] WRAP_RESET = 20'd4096;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CODE_NUL    = 8'h00;
  localparam logic [7:0] CODE_TAB    = 8'h09;
  localparam logic [7:0] CODE_NL     = 8'h0A;
  localparam logic [7:0] CODE_ESC    = 8'h10;
  localparam logic [7:0] CODE_HASHIN = 8'h1F;
  localparam logic [7:0] CODE_SPACE  = 8'h20;
  localparam logic [7:0] CODE_DEL    = 8'h7F;

  localparam logic [6:0] SPACE_UNITS = 7'd16;
  localparam logic [6:0] TAB_UNITS   = 7'd64;
  localparam logic [6:0] HASH_UNITS  = 7'd26;

  // Output queue depth and pointer width.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;

  // Glyph widths for codes 0x20 to 0x7E.
  localparam logic [5:0] GLYPH_UNITS [0:94] = '{
    6'd16, 6'd8,  6'd13, 6'd26, 6'd19, 6'd46, 6'd34, 6'd6,
    6'd15, 6'd14, 6'd20, 6'd31, 6'd9,  6'd13, 6'd8,  6'd21,
    6'd27, 6'd13, 6'd23, 6'd21, 6'd28, 6'd23, 6'd25, 6'd24,
    6'd24, 6'd25, 6'd8,  6'd9,  6'd31, 6'd30, 6'd31, 6'd15,
    6'd40, 6'd32, 6'd22, 6'd28, 6'd32, 6'd21, 6'd21, 6'd33,
    6'd33, 6'd8,  6'd16, 6'd29, 6'd20, 6'd45, 6'd33, 6'd38,
    6'd23, 6'd38, 6'd29, 6'd19, 6'd30, 6'd31, 6'd32, 6'd51,
    6'd29, 6'd29, 6'd25, 6'd13, 6'd21, 6'd13, 6'd30, 6'd26,
    6'd12, 6'd22, 6'd24, 6'd20, 6'd25, 6'd22, 6'd17, 6'd24,
    6'd23, 6'd8,  6'd13, 6'd23, 6'd8,  6'd39, 6'd24, 6'd27,
    6'd25, 6'd25, 6'd17, 6'd13, 6'd16, 6'd23, 6'd26, 6'd40,
    6'd23, 6'd26, 6'd21, 6'd18, 6'd5,  6'd18, 6'd35
  };

  // Running sums of the line being built.
  typedef struct packed {
    logic [WIDTH_W-1:0]  line_accum;
    logic [WIDTH_W-1:0]  word_accum;
    logic [WIDTH_W-1:0]  gap_accum;
    logic [OFFSET_W-1:0] word_begin;
    logic [WIDTH_W-1:0]  widest;
  } wrap_state_t;

  // One finished line.
  typedef struct packed {
    logic [INDEX_W-1:0]  line_index;
    logic [WIDTH_W-1:0]  line_width;
    logic [OFFSET_W-1:0] next_start;
    logic [WIDTH_W-1:0]  max_width;
    logic                line_overflow;
    logic                text_done;
  } line_result_t;

  // Sequencer that replays the bytes of a broken colour escape.
  typedef enum logic [1:0] {
    RP_IDLE,
    RP_HELD0,
    RP_HELD1,
    RP_ZERO
  } replay_state_t;

endpackage

### rtl/core/gwwl_if.sv
// Handshake interfaces for the character input and the line result output.
// Depends on gwwl_pkg for the field widths.
interface gwwl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface gwwl_line_if;
  logic                             valid;
  logic                             ready;
  logic [gwwl_pkg::INDEX_W-1:0]     line_index;
  logic [gwwl_pkg::WIDTH_W-1:0]     line_width;
  logic [gwwl_pkg::OFFSET_W-1:0]    next_start;
  logic [gwwl_pkg::WIDTH_W-1:0]     max_width;
  logic                             line_overflow;
  logic                             text_done;

  modport source (output valid, output line_index, output line_width, output next_start,
                  output max_width, output line_overflow, output text_done, input ready);
  modport sink (input valid, input line_index, input line_width, input next_start,
                input max_width, input line_overflow, input text_done, output ready);
endinterface

### rtl/core/gwwl_step.sv
// Combinational step for one text byte: word close, line break, gap and width sums.
// Depends on gwwl_pkg; yields up to two finished lines per byte.
module gwwl_step #(
  parameter int MAX_LINES = 64,
  parameter int MAX_TEXT  = 65535,
  parameter int CNT_W     = 7
) (
  input  logic [7:0]                      char_code,
  input  logic [gwwl_pkg::OFFSET_W-1:0]   offset,
  input  logic [gwwl_pkg::WIDTH_W-1:0]    wrap_width,
  input  gwwl_pkg::wrap_state_t           st,
  input  logic [CNT_W-1:0]                lines,
  output gwwl_pkg::wrap_state_t           st_next,
  output logic [CNT_W-1:0]                lines_next,
  output logic                            res0_valid,
  output gwwl_pkg::line_result_t          res0,
  output logic                            res1_valid,
  output gwwl_pkg::line_result_t          res1
);

  localparam logic [CNT_W-1:0] LINE_LIMIT = CNT_W'(MAX_LINES);
  localparam logic [16:0]      TEXT_LIMIT = 17'(MAX_TEXT);

  always_comb begin
    logic                         is_ctrl;
    logic                         close_word;
    logic                         do_break;
    logic                         is_zero;
    logic                         is_nl;
    logic [gwwl_pkg::WIDTH_W+1:0] full_sum;
    logic [gwwl_pkg::WIDTH_W:0]   add_sum;
    logic [gwwl_pkg::WIDTH_W-1:0] line_a;
    logic [gwwl_pkg::WIDTH_W-1:0] word_a;
    logic [gwwl_pkg::WIDTH_W-1:0] gap_a;
    logic [gwwl_pkg::WIDTH_W-1:0] widest1;
    logic [CNT_W-1:0]             lines1;
    logic [16:0]                  off_inc;
    logic [gwwl_pkg::OFFSET_W-1:0] off_plus;
    logic [6:0]                   units;

    is_ctrl    = (char_code <= gwwl_pkg::CODE_SPACE) || (char_code >= gwwl_pkg::CODE_DEL);
    close_word = is_ctrl && !char_code[4] && (st.word_accum != '0);
    is_zero    = (char_code == gwwl_pkg::CODE_NUL);
    is_nl      = (char_code == gwwl_pkg::CODE_NL);

    off_inc  = {1'b0, offset} + 17'd1;
    off_plus = (off_inc > TEXT_LIMIT) ? TEXT_LIMIT[15:0] : off_inc[15:0];

    // Line plus gap plus word, unsaturated for the compare.
    full_sum = {2'b00, st.line_accum} + {2'b00, st.gap_accum} + {2'b00, st.word_accum};
    do_break = close_word && (st.line_accum != '0)
               && (full_sum > {2'b00, wrap_width});

    line_a = st.line_accum;
    word_a = st.word_accum;
    gap_a  = st.gap_accum;
    if (close_word) begin
      if (do_break) begin
        line_a = st.word_accum;
      end else begin
        line_a = (full_sum > {2'b00, gwwl_pkg::WIDTH_MAX}) ? gwwl_pkg::WIDTH_MAX
                                                            : full_sum[19:0];
      end
      word_a = '0;
      gap_a  = '0;
    end

    // First line: the one the word would have overfilled.
    res0_valid         = do_break;
    res0.line_width    = st.line_accum;
    res0.next_start    = st.word_begin;
    res0.text_done     = 1'b0;
    lines1             = lines;
    res0.line_index    = 7'(lines);
    res0.line_overflow = 1'b0;
    if (lines >= LINE_LIMIT) begin
      res0.line_index    = 7'(LINE_LIMIT);
      res0.line_overflow = 1'b1;
    end else if (do_break) begin
      lines1 = lines + 1'b1;
    end
    widest1 = st.widest;
    if (do_break && (st.line_accum > st.widest)) begin
      widest1 = st.line_accum;
    end
    res0.max_width = widest1;

    // Second line: closed by a newline or by the end of the string.
    res1_valid         = is_zero || is_nl;
    res1.line_width    = line_a;
    res1.next_start    = is_zero ? offset : off_plus;
    res1.text_done     = is_zero;
    lines_next         = lines1;
    res1.line_index    = 7'(lines1);
    res1.line_overflow = 1'b0;
    if (lines1 >= LINE_LIMIT) begin
      res1.line_index    = 7'(LINE_LIMIT);
      res1.line_overflow = 1'b1;
    end else if (res1_valid) begin
      lines_next = lines1 + 1'b1;
    end
    st_next.widest = widest1;
    if (res1_valid && (line_a > widest1)) begin
      st_next.widest = line_a;
    end
    res1.max_width = st_next.widest;

    st_next.line_accum = line_a;
    st_next.word_accum = word_a;
    st_next.gap_accum  = gap_a;
    st_next.word_begin = st.word_begin;

    units = gwwl_pkg::HASH_UNITS;
    if (!is_ctrl) begin
      units = {1'b0, gwwl_pkg::GLYPH_UNITS[7'(char_code - gwwl_pkg::CODE_SPACE)]};
    end

    add_sum = '0;
    if (is_zero) begin
      st_next    = '0;
      lines_next = '0;
    end else if (is_nl) begin
      st_next.gap_accum  = '0;
      st_next.line_accum = '0;
    end else if ((char_code == gwwl_pkg::CODE_SPACE) || (char_code == gwwl_pkg::CODE_TAB)) begin
      add_sum = {1'b0, gap_a} + 21'((char_code == gwwl_pkg::CODE_SPACE) ?
                                    gwwl_pkg::SPACE_UNITS : gwwl_pkg::TAB_UNITS);
      st_next.gap_accum  = add_sum[20] ? gwwl_pkg::WIDTH_MAX : add_sum[19:0];
      st_next.word_begin = off_plus;
    end else begin
      add_sum = {1'b0, word_a} + 21'(units);
      st_next.word_accum = add_sum[20] ? gwwl_pkg::WIDTH_MAX : add_sum[19:0];
    end
  end

endmodule

### rtl/core/gwwl_out_fifo.sv
// Output queue of finished lines: takes up to two lines per cycle, gives one.
// Depends on gwwl_pkg for the line result type and the queue depth.
module gwwl_out_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push0,
  input  gwwl_pkg::line_result_t data0,
  input  logic                   push1,
  input  gwwl_pkg::line_result_t data1,
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_ready,
  output gwwl_pkg::line_result_t out_data
);

  gwwl_pkg::line_result_t        entries [gwwl_pkg::OQ_DEPTH];
  logic [gwwl_pkg::OQ_PTR_W-1:0] wr_ptr;
  logic [gwwl_pkg::OQ_PTR_W-1:0] rd_ptr;
  logic [gwwl_pkg::OQ_PTR_W:0]   count;
  logic [1:0]                    n_push;
  logic                          pop;
  gwwl_pkg::line_result_t        first_data;

  assign n_push     = {1'b0, push0} + {1'b0, push1};
  assign first_data = push0 ? data0 : data1;
  assign pop        = out_valid && out_ready;
  assign out_valid  = (count != '0);
  assign out_data   = entries[rd_ptr];
  // Room for the two lines a single byte can close.
  assign room       = (count <= (gwwl_pkg::OQ_PTR_W+1)'(gwwl_pkg::OQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + gwwl_pkg::OQ_PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (gwwl_pkg::OQ_PTR_W+1)'(n_push)
                     - (gwwl_pkg::OQ_PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entries[wr_ptr] <= first_data;
    end
    if (n_push == 2'd2) begin
      entries[wr_ptr + 1'b1] <= data1;
    end
  end

endmodule

### rtl/core/greedy_word_wrap_line_breaker.sv
// Greedy word-wrap line breaker: byte input, escape handling and line result output.
// Depends on gwwl_pkg, gwwl_if, gwwl_step and gwwl_out_fifo.
//
// Use: text bytes enter on char_in, one item per byte; a zero byte ends the string.
// Each finished line leaves on line_out as one item carrying its index, width, the
// offset of the next line, the widest line so far, a count overflow flag and, on the
// last line of the string, text_done. wrap_width is written through cfg_we and
// cfg_wdata while the block is idle.
// With an empty queue, the first line closed by a byte is offered on line_out in the
// cycle after that byte is taken, and a second line once the first has been taken.
// Throughput is one byte per cycle while char_in.ready is high, set by the combinational
// step logic feeding a four-entry output queue that takes up to two lines per cycle.
// char_in.ready is low while the queue has fewer than two free entries, so a
// stalled receiver holds the input back once three or more lines are queued; nothing
// is lost. A zero byte that breaks an open colour escape starts a replay of one step
// per held byte and one for the zero, each waiting for two free queue entries, during
// which ready is low.
// Reset clears all running sums, counters, the escape state and the queue, and sets
// wrap_width to 4096.
module greedy_word_wrap_line_breaker #(
  parameter int MAX_LINES = 64,
  parameter int MAX_TEXT  = 65535
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gwwl_pkg::WIDTH_W-1:0]  cfg_wdata,
  gwwl_char_if.sink                     char_in,
  gwwl_line_if.source                   line_out
);

  // Wide enough for the saturated line count itself.
  localparam int CNT_W = $clog2(MAX_LINES + 1);
  localparam logic [16:0] TEXT_LIMIT = 17'(MAX_TEXT);

  logic [gwwl_pkg::WIDTH_W-1:0]  wrap_width;
  gwwl_pkg::wrap_state_t         st;
  logic [CNT_W-1:0]              lines;
  logic [gwwl_pkg::OFFSET_W-1:0] byte_offset;
  logic [1:0]                    escape_pending;
  logic [7:0]                    escape_held [2];
  gwwl_pkg::replay_state_t       rp_state;
  gwwl_pkg::replay_state_t       rp_state_next;
  logic                          rep_two;
  logic [gwwl_pkg::OFFSET_W-1:0] rep_off;

  // Step inputs and outputs.
  logic [7:0]                    step_code;
  logic [gwwl_pkg::OFFSET_W-1:0] step_off;
  logic                          step_apply;
  gwwl_pkg::wrap_state_t         st_next;
  logic [CNT_W-1:0]              lines_next;
  logic                          res0_valid;
  logic                          res1_valid;
  gwwl_pkg::line_result_t        res0;
  gwwl_pkg::line_result_t        res1;

  logic                          room;
  logic                          accept;
  logic [7:0]                    code;
  logic                          fifo_valid;
  gwwl_pkg::line_result_t        head;
  logic [16:0]                   off_inc1;
  logic [16:0]                   off_inc4;
  logic [16:0]                   rep_inc;

  assign code     = char_in.char_code;
  assign accept   = char_in.valid && char_in.ready;
  assign char_in.ready = (rp_state == gwwl_pkg::RP_IDLE) && room;

  assign off_inc1 = {1'b0, byte_offset} + 17'd1;
  assign off_inc4 = {1'b0, byte_offset} + 17'd4;
  assign rep_inc  = {1'b0, rep_off} + 17'd1;

  // Next state of the escape replay sequencer.
  always_comb begin
    rp_state_next = rp_state;
    case (rp_state)
      gwwl_pkg::RP_IDLE: begin
        if (accept && (escape_pending != 2'd0) && (code == gwwl_pkg::CODE_NUL)) begin
          rp_state_next = (escape_pending == 2'd1) ? gwwl_pkg::RP_ZERO : gwwl_pkg::RP_HELD0;
        end
      end
      gwwl_pkg::RP_HELD0: begin
        if (room) begin
          rp_state_next = rep_two ? gwwl_pkg::RP_HELD1 : gwwl_pkg::RP_ZERO;
        end
      end
      gwwl_pkg::RP_HELD1: begin
        if (room) begin
          rp_state_next = gwwl_pkg::RP_ZERO;
        end
      end
      gwwl_pkg::RP_ZERO: begin
        if (room) begin
          rp_state_next = gwwl_pkg::RP_IDLE;
        end
      end
      default: rp_state_next = gwwl_pkg::RP_IDLE;
    endcase
  end

  // Which byte the step logic sees, and whether its result is kept.
  always_comb begin
    step_code  = code;
    step_off   = byte_offset;
    step_apply = 1'b0;
    case (rp_state)
      gwwl_pkg::RP_IDLE: begin
        // A broken escape first counts its opener as a joining '#'.
        if (escape_pending != 2'd0) begin
          step_code  = gwwl_pkg::CODE_HASHIN;
          step_apply = accept && (code == gwwl_pkg::CODE_NUL);
        end else begin
          step_apply = accept && (code != gwwl_pkg::CODE_ESC);
        end
      end
      gwwl_pkg::RP_HELD0: begin
        step_code  = escape_held[0];
        step_off   = rep_off;
        step_apply = room;
      end
      gwwl_pkg::RP_HELD1: begin
        step_code  = escape_held[1];
        step_off   = rep_off;
        step_apply = room;
      end
      gwwl_pkg::RP_ZERO: begin
        step_code  = gwwl_pkg::CODE_NUL;
        step_off   = rep_off;
        step_apply = room;
      end
      default: begin
        step_apply = 1'b0;
      end
    endcase
  end

  gwwl_step #(
    .MAX_LINES (MAX_LINES),
    .MAX_TEXT  (MAX_TEXT),
    .CNT_W     (CNT_W)
  ) u_step (
    .char_code  (step_code),
    .offset     (step_off),
    .wrap_width (wrap_width),
    .st         (st),
    .lines      (lines),
    .st_next    (st_next),
    .lines_next (lines_next),
    .res0_valid (res0_valid),
    .res0       (res0),
    .res1_valid (res1_valid),
    .res1       (res1)
  );

  gwwl_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push0     (step_apply && res0_valid),
    .data0     (res0),
    .push1     (step_apply && res1_valid),
    .data1     (res1),
    .room      (room),
    .out_valid (fifo_valid),
    .out_ready (line_out.ready),
    .out_data  (head)
  );

  assign line_out.valid         = fifo_valid;
  assign line_out.line_index    = head.line_index;
  assign line_out.line_width    = head.line_width;
  assign line_out.next_start    = head.next_start;
  assign line_out.max_width     = head.max_width;
  assign line_out.line_overflow = head.line_overflow;
  assign line_out.text_done     = head.text_done;

  // Control state: sums, counters, offsets and the escape tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_width     <= gwwl_pkg::WRAP_RESET;
      st             <= '0;
      lines          <= '0;
      byte_offset    <= '0;
      escape_pending <= 2'd0;
      rp_state       <= gwwl_pkg::RP_IDLE;
    end else begin
      rp_state <= rp_state_next;
      if (cfg_we) begin
        wrap_width <= cfg_wdata;
      end
      if (step_apply) begin
        st    <= st_next;
        lines <= lines_next;
      end
      if ((rp_state == gwwl_pkg::RP_IDLE) && accept) begin
        if (escape_pending != 2'd0) begin
          if (code != gwwl_pkg::CODE_NUL) begin
            if (escape_pending != 2'd3) begin
              escape_pending <= escape_pending + 2'd1;
            end else begin
              // A complete escape is skipped whole.
              escape_pending <= 2'd0;
              byte_offset    <= (off_inc4 > TEXT_LIMIT) ? TEXT_LIMIT[15:0] : off_inc4[15:0];
            end
          end else begin
            escape_pending <= 2'd0;
          end
        end else if (code == gwwl_pkg::CODE_ESC) begin
          escape_pending <= 2'd1;
        end else if (code == gwwl_pkg::CODE_NUL) begin
          byte_offset <= '0;
        end else begin
          byte_offset <= (off_inc1 > TEXT_LIMIT) ? TEXT_LIMIT[15:0] : off_inc1[15:0];
        end
      end
      if ((rp_state == gwwl_pkg::RP_ZERO) && room) begin
        byte_offset <= '0;
      end
    end
  end

  // Escape followers and replay bookkeeping carry no reset.
  always_ff @(posedge clk) begin
    if ((rp_state == gwwl_pkg::RP_IDLE) && accept && (escape_pending != 2'd0)) begin
      if ((code != gwwl_pkg::CODE_NUL) && (escape_pending != 2'd3)) begin
        escape_held[escape_pending[1]] <= code;
      end
      if (code == gwwl_pkg::CODE_NUL) begin
        rep_two <= (escape_pending == 2'd3);
        rep_off <= (off_inc1 > TEXT_LIMIT) ? TEXT_LIMIT[15:0] : off_inc1[15:0];
      end
    end
    if ((rp_state != gwwl_pkg::RP_IDLE) && room) begin
      rep_off <= (rep_inc > TEXT_LIMIT) ? TEXT_LIMIT[15:0] : rep_inc[15:0];
    end
  end

endmodule
